// ===== design/ets_pkg.sv =====
`default_nettype none
package ets_pkg;

    // token kinds
    localparam logic [3:0] K_INT   = 4'd0;
    localparam logic [3:0] K_DEC   = 4'd1;
    localparam logic [3:0] K_IDENT = 4'd2;
    localparam logic [3:0] K_PLUS  = 4'd3;
    localparam logic [3:0] K_INCR  = 4'd4;
    localparam logic [3:0] K_MINUS = 4'd5;
    localparam logic [3:0] K_DECR  = 4'd6;
    localparam logic [3:0] K_MUL   = 4'd7;
    localparam logic [3:0] K_DIV   = 4'd8;
    localparam logic [3:0] K_OPEN  = 4'd9;
    localparam logic [3:0] K_CLOSE = 4'd10;
    localparam logic [3:0] K_END   = 4'd11;
    localparam logic [3:0] K_ERROR = 4'd12;

    // error kinds
    localparam logic [2:0] E_NONE      = 3'd0;
    localparam logic [2:0] E_BAD_START = 3'd1;
    localparam logic [2:0] E_NUM_ALPHA = 3'd2;
    localparam logic [2:0] E_DEC_ALPHA = 3'd3;
    localparam logic [2:0] E_ID_SYMBOL = 3'd4;
    localparam logic [2:0] E_LONE_DOT  = 3'd5;

    // character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;

    // queue between scanner and emitter
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [31:0] int_value;
        logic [31:0] frac_value;
        logic [7:0]  frac_count;
        logic [7:0]  lexeme_length;
        logic [15:0] start_row;
        logic [15:0] start_col;
        logic [2:0]  error_kind;
    } t_token;

    // tokens caused by one character: one or two
    typedef struct packed {
        logic   two;
        t_token tok0;
        t_token tok1;
    } t_rec;

endpackage
`default_nettype wire

// ===== design/ets_if.sv =====
`default_nettype none
interface ets_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_input;
    modport source(output valid, char_code, end_of_input, input ready);
    modport sink(input valid, char_code, end_of_input, output ready);
endinterface

interface ets_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [31:0] int_value;
    logic [31:0] frac_value;
    logic [7:0]  frac_count;
    logic [7:0]  lexeme_length;
    logic [15:0] start_row;
    logic [15:0] start_col;
    logic [2:0]  error_kind;
    logic        last;
    modport source(output valid, token_kind, int_value, frac_value, frac_count,
                   lexeme_length, start_row, start_col, error_kind, last, input ready);
    modport sink(input valid, token_kind, int_value, frac_value, frac_count,
                 lexeme_length, start_row, start_col, error_kind, last, output ready);
endinterface
`default_nettype wire

// ===== design/ets_front.sv =====
`default_nettype none
module ets_front #(
    parameter int LENGTH_LIMIT = 255
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [7:0]    i_char_code,
    input  wire logic          i_end_of_input,
    input  wire logic          i_q_full,
    output logic               o_ready,
    output logic               o_push,
    output ets_pkg::t_rec      o_rec
);
    import ets_pkg::*;

    localparam int LW = $clog2(LENGTH_LIMIT + 1);

    localparam logic [2:0] M_START   = 3'd0;
    localparam logic [2:0] M_NUMBER  = 3'd1;
    localparam logic [2:0] M_DECIMAL = 3'd2;
    localparam logic [2:0] M_IDENT   = 3'd3;
    localparam logic [2:0] M_PLUS    = 3'd4;
    localparam logic [2:0] M_MINUS   = 3'd5;

    logic [2:0]    r_mode, n_mode;
    logic [31:0]   r_int, n_int;
    logic [31:0]   r_frac, n_frac;
    logic [7:0]    r_fdig, n_fdig;
    logic          r_suffix, n_suffix;
    logic [LW-1:0] r_len, n_len;
    logic [15:0]   r_line, n_line;
    logic [15:0]   r_col, n_col;
    logic [15:0]   r_trow, n_trow;
    logic [15:0]   r_tcol, n_tcol;
    logic          r_halted, n_halted;

    logic          w_fire;
    logic [7:0]    w_c;
    logic [3:0]    w_d;
    logic          w_digit, w_letter, w_symbol, w_space;
    logic [15:0]   w_prow, w_pcol;
    logic [LW-1:0] w_len_inc;
    logic [7:0]    w_len_out;
    logic          w_do_begin, w_use_flush;
    t_token        w_ftok, w_btok;
    logic          w_fv, w_bv;

    assign o_ready = !i_q_full;
    assign w_fire  = i_valid && o_ready;

    // character classes
    assign w_c      = i_char_code;
    assign w_d      = w_c[3:0];
    assign w_digit  = (w_c >= CH_ZERO) && (w_c <= CH_NINE);
    assign w_letter = ((w_c >= CH_LO_A) && (w_c <= CH_LO_Z)) ||
                      ((w_c >= CH_UP_A) && (w_c <= CH_UP_Z));
    assign w_symbol = (w_c == CH_PLUS) || (w_c == CH_MINUS) || (w_c == CH_STAR) ||
                      (w_c == CH_SLASH) || (w_c == CH_DOT) || (w_c == CH_OPEN) ||
                      (w_c == CH_CLOSE);
    assign w_space  = (w_c == CH_SPACE) || (w_c == CH_NL) || (w_c == CH_TAB);

    // position after this character
    always_comb begin
        w_prow = r_line;
        w_pcol = r_col;
        if (w_c == CH_NL) begin
            if (r_line != 16'hFFFF) w_prow = r_line + 16'd1;
            w_pcol = 16'd0;
        end else if (r_col != 16'hFFFF) begin
            w_pcol = r_col + 16'd1;
        end
    end

    // saturating lexeme length
    assign w_len_inc = (r_len < LW'(LENGTH_LIMIT)) ? r_len + LW'(1) : r_len;
    assign w_len_out = (16'(r_len) > 16'd255) ? 8'hFF : 8'(r_len);

    // token pending in the current mode
    always_comb begin
        w_ftok           = '0;
        w_ftok.start_row = r_trow;
        w_ftok.start_col = r_tcol;
        w_fv             = 1'b1;
        case (r_mode)
            M_NUMBER: begin
                w_ftok.token_kind    = K_INT;
                w_ftok.int_value     = r_int;
                w_ftok.lexeme_length = w_len_out;
            end
            M_DECIMAL: begin
                w_ftok.token_kind    = K_DEC;
                w_ftok.int_value     = r_int;
                w_ftok.frac_value    = r_frac;
                w_ftok.frac_count    = r_fdig;
                w_ftok.lexeme_length = w_len_out;
            end
            M_IDENT: begin
                w_ftok.token_kind    = K_IDENT;
                w_ftok.lexeme_length = w_len_out;
            end
            M_PLUS: begin
                w_ftok.token_kind    = K_PLUS;
                w_ftok.lexeme_length = 8'd1;
            end
            M_MINUS: begin
                w_ftok.token_kind    = K_MINUS;
                w_ftok.lexeme_length = 8'd1;
            end
            default: begin
                w_fv = 1'b0;
            end
        endcase
    end

    // scanner step
    always_comb begin
        n_mode      = r_mode;
        n_int       = r_int;
        n_frac      = r_frac;
        n_fdig      = r_fdig;
        n_suffix    = r_suffix;
        n_len       = r_len;
        n_line      = r_line;
        n_col       = r_col;
        n_trow      = r_trow;
        n_tcol      = r_tcol;
        n_halted    = r_halted;
        w_do_begin  = 1'b0;
        w_use_flush = 1'b0;
        w_bv        = 1'b0;
        w_btok      = '0;
        w_btok.start_row = w_prow;
        w_btok.start_col = w_pcol;

        if (!r_halted) begin
            if (i_end_of_input) begin
                w_use_flush      = 1'b1;
                w_bv             = 1'b1;
                w_btok.token_kind = K_END;
                w_btok.start_row = r_line;
                w_btok.start_col = r_col;
                n_mode           = M_START;
                n_line           = 16'd1;
                n_col            = 16'd0;
            end else begin
                n_line = w_prow;
                n_col  = w_pcol;
                case (r_mode)
                    M_NUMBER: begin
                        if (w_digit) begin
                            n_int = {r_int[28:0], 3'b000} + {r_int[30:0], 1'b0} +
                                    {28'd0, w_d};
                            n_len = w_len_inc;
                        end else if (w_letter) begin
                            w_bv              = 1'b1;
                            w_btok.token_kind = K_ERROR;
                            w_btok.error_kind = E_NUM_ALPHA;
                        end else if (w_c == CH_DOT) begin
                            n_len    = w_len_inc;
                            n_frac   = 32'd0;
                            n_fdig   = 8'd0;
                            n_suffix = 1'b0;
                            n_mode   = M_DECIMAL;
                        end else begin
                            w_use_flush = 1'b1;
                            w_do_begin  = 1'b1;
                        end
                    end
                    M_DECIMAL: begin
                        if (w_digit) begin
                            n_frac = {r_frac[28:0], 3'b000} + {r_frac[30:0], 1'b0} +
                                     {28'd0, w_d};
                            if (r_fdig != 8'hFF) n_fdig = r_fdig + 8'd1;
                            n_len = w_len_inc;
                        end else if (w_letter) begin
                            if (!r_suffix && ((w_c == CH_LO_F) || (w_c == CH_UP_F))) begin
                                n_suffix = 1'b1;
                            end else begin
                                w_bv              = 1'b1;
                                w_btok.token_kind = K_ERROR;
                                w_btok.error_kind = E_DEC_ALPHA;
                            end
                        end else begin
                            w_use_flush = 1'b1;
                            w_do_begin  = 1'b1;
                        end
                    end
                    M_IDENT: begin
                        if (w_digit || w_letter) begin
                            n_len = w_len_inc;
                        end else if (w_symbol) begin
                            w_bv              = 1'b1;
                            w_btok.token_kind = K_ERROR;
                            w_btok.error_kind = E_ID_SYMBOL;
                        end else begin
                            w_use_flush = 1'b1;
                            w_do_begin  = 1'b1;
                        end
                    end
                    M_PLUS, M_MINUS: begin
                        if ((r_mode == M_PLUS && w_c == CH_PLUS) ||
                            (r_mode == M_MINUS && w_c == CH_MINUS)) begin
                            w_bv                 = 1'b1;
                            w_btok.token_kind    = (r_mode == M_PLUS) ? K_INCR : K_DECR;
                            w_btok.lexeme_length = 8'd2;
                            w_btok.start_row     = r_trow;
                            w_btok.start_col     = r_tcol;
                            n_mode               = M_START;
                        end else begin
                            w_use_flush = 1'b1;
                            w_do_begin  = 1'b1;
                        end
                    end
                    default: begin
                        w_do_begin = 1'b1;
                    end
                endcase

                // start of a new token
                if (w_do_begin) begin
                    n_mode = M_START;
                    if (w_space) begin
                        n_mode = M_START;
                    end else if (w_digit) begin
                        n_trow   = w_prow;
                        n_tcol   = w_pcol;
                        n_len    = LW'(1);
                        n_int    = {28'd0, w_d};
                        n_frac   = 32'd0;
                        n_fdig   = 8'd0;
                        n_suffix = 1'b0;
                        n_mode   = M_NUMBER;
                    end else if (w_letter || w_c == CH_PLUS || w_c == CH_MINUS) begin
                        n_trow = w_prow;
                        n_tcol = w_pcol;
                        n_len  = LW'(1);
                        n_mode = w_letter ? M_IDENT :
                                 (w_c == CH_PLUS) ? M_PLUS : M_MINUS;
                    end else if (w_c == CH_STAR || w_c == CH_SLASH ||
                                 w_c == CH_OPEN || w_c == CH_CLOSE) begin
                        w_bv                 = 1'b1;
                        w_btok.lexeme_length = 8'd1;
                        w_btok.token_kind    = (w_c == CH_STAR)  ? K_MUL :
                                               (w_c == CH_SLASH) ? K_DIV :
                                               (w_c == CH_OPEN)  ? K_OPEN : K_CLOSE;
                    end else begin
                        w_bv              = 1'b1;
                        w_btok.token_kind = K_ERROR;
                        w_btok.error_kind = (w_c == CH_DOT) ? E_LONE_DOT : E_BAD_START;
                    end
                end

                // an error halts the scanner
                if (w_bv && w_btok.token_kind == K_ERROR) begin
                    n_halted = 1'b1;
                    n_mode   = M_START;
                end
            end
        end
    end

    // pack the tokens of this beat
    assign o_push        = w_fire && ((w_use_flush && w_fv) || w_bv);
    assign o_rec.two     = w_use_flush && w_fv && w_bv;
    assign o_rec.tok0    = (w_use_flush && w_fv) ? w_ftok : w_btok;
    assign o_rec.tok1    = w_btok;

    // scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_START;
            r_int    <= 32'd0;
            r_frac   <= 32'd0;
            r_fdig   <= 8'd0;
            r_suffix <= 1'b0;
            r_len    <= '0;
            r_line   <= 16'd1;
            r_col    <= 16'd0;
            r_trow   <= 16'd0;
            r_tcol   <= 16'd0;
            r_halted <= 1'b0;
        end else if (w_fire) begin
            r_mode   <= n_mode;
            r_int    <= n_int;
            r_frac   <= n_frac;
            r_fdig   <= n_fdig;
            r_suffix <= n_suffix;
            r_len    <= n_len;
            r_line   <= n_line;
            r_col    <= n_col;
            r_trow   <= n_trow;
            r_tcol   <= n_tcol;
            r_halted <= n_halted;
        end
    end

endmodule
`default_nettype wire

// ===== design/ets_queue.sv =====
`default_nettype none
module ets_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ets_pkg::t_rec i_rec,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_empty,
    output ets_pkg::t_rec      o_head
);
    import ets_pkg::*;

    t_rec           r_mem [QDEPTH];
    logic [QAW-1:0] r_wptr, r_rptr;
    logic [QAW:0]   r_count;
    logic           w_do_push, w_do_pop;

    assign o_full    = (r_count == (QAW+1)'(QDEPTH));
    assign o_empty   = (r_count == '0);
    assign o_head    = r_mem[r_rptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) r_mem[r_wptr] <= i_rec;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) r_wptr <= r_wptr + QAW'(1);
            if (w_do_pop)  r_rptr <= r_rptr + QAW'(1);
            if (w_do_push && !w_do_pop)      r_count <= r_count + (QAW+1)'(1);
            else if (w_do_pop && !w_do_push) r_count <= r_count - (QAW+1)'(1);
        end
    end

endmodule
`default_nettype wire

// ===== design/ets_back.sv =====
`default_nettype none
module ets_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    input  wire ets_pkg::t_rec i_head,
    input  wire logic          i_ready,
    output logic               o_pop,
    output logic               o_valid,
    output ets_pkg::t_token    o_token,
    output logic               o_last
);
    import ets_pkg::*;

    logic r_sel;
    logic w_fire;

    // one token per beat, second slot after the first
    assign o_valid = !i_empty;
    assign o_token = r_sel ? i_head.tok1 : i_head.tok0;
    assign o_last  = r_sel || !i_head.two;
    assign w_fire  = o_valid && i_ready;
    assign o_pop   = w_fire && o_last;

    // slot select
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= 1'b0;
        end else if (w_fire) begin
            r_sel <= !o_last;
        end
    end

endmodule
`default_nettype wire

// ===== design/expression_token_scanner_top.sv =====
`default_nettype none
// Expression token scanner. One source byte (or an end mark) is taken per beat on i_in,
// and tokens leave on o_out one per beat, with last set on the final token caused by
// that input beat. The scanner takes a byte every cycle as long as its four-entry
// queue of token groups has room; a byte yields zero, one or two tokens, so output
// runs at one token per cycle while the consumer is ready; a stalled consumer only
// back-pressures the input once the queue fills. Tokens are written into the queue
// when their closing byte is accepted. After an error token every further beat is taken
// and dropped until reset. LENGTH_LIMIT sets where the lexeme length count saturates.
module expression_token_scanner_top #(
    parameter int LENGTH_LIMIT = 255
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ets_in_if.sink    i_in,
    ets_out_if.source o_out
);
    import ets_pkg::*;

    logic   w_push, w_full, w_empty, w_pop;
    t_rec   w_rec, w_head;
    t_token w_token;

    // front: classify and scan
    ets_front #(
        .LENGTH_LIMIT(LENGTH_LIMIT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in.valid),
        .i_char_code    (i_in.char_code),
        .i_end_of_input (i_in.end_of_input),
        .i_q_full       (w_full),
        .o_ready        (i_in.ready),
        .o_push         (w_push),
        .o_rec          (w_rec)
    );

    // token group queue
    ets_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_rec),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    // back: emit tokens
    ets_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_head  (w_head),
        .i_ready (o_out.ready),
        .o_pop   (w_pop),
        .o_valid (o_out.valid),
        .o_token (w_token),
        .o_last  (o_out.last)
    );

    assign o_out.token_kind    = w_token.token_kind;
    assign o_out.int_value     = w_token.int_value;
    assign o_out.frac_value    = w_token.frac_value;
    assign o_out.frac_count    = w_token.frac_count;
    assign o_out.lexeme_length = w_token.lexeme_length;
    assign o_out.start_row     = w_token.start_row;
    assign o_out.start_col     = w_token.start_col;
    assign o_out.error_kind    = w_token.error_kind;

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
    import ets_pkg::*;

    localparam int LEN_LIMIT   = 255;
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef enum logic [2:0] {
        SM_START, SM_NUMBER, SM_DECIMAL, SM_IDENT, SM_PLUS, SM_MINUS
    } t_scan_mode;

    typedef struct {
        t_scan_mode  mode;
        logic [31:0] ival;
        logic [31:0] fval;
        logic [7:0]  fdigits;
        logic        suffix;
        int unsigned len;
        logic [15:0] row;
        logic [15:0] col;
        logic [15:0] trow;
        logic [15:0] tcol;
        logic        halted;
    } t_scan_state;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] ival;
        logic [31:0] fval;
        logic [7:0]  fcount;
        logic [7:0]  len;
        logic [15:0] row;
        logic [15:0] col;
        logic [2:0]  err;
        logic        last;
    } t_exp_token;

    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
    } t_src_beat;

    logic clk;
    logic rst_n;

    ets_in_if  in_if();
    ets_out_if out_if();

    expression_token_scanner_top uut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // beats waiting to be sent, tokens waiting to arrive
    t_src_beat   source_beats[$];
    t_exp_token  tokens_due[$];
    t_scan_state scanner_model;
    t_scan_state gen_model;

    int beats_queued;
    int beats_sent;
    int beats_taken;
    int fail_count;
    int cycle_count;
    int sender_idle_pct;
    int receiver_idle_pct;

    // character classes
    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
    endfunction

    function automatic bit is_op_char(logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
               c == CH_DOT || c == CH_OPEN || c == CH_CLOSE;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_NL || c == CH_TAB;
    endfunction

    // scanner state after reset
    function automatic t_scan_state scan_reset();
        t_scan_state s;
        s.mode    = SM_START;
        s.ival    = '0;
        s.fval    = '0;
        s.fdigits = '0;
        s.suffix  = 1'b0;
        s.len     = 0;
        s.row     = 16'd1;
        s.col     = '0;
        s.trow    = '0;
        s.tcol    = '0;
        s.halted  = 1'b0;
        return s;
    endfunction

    function automatic void put_tok(ref t_exp_token toks[$], input logic [3:0] kind,
                                    input logic [31:0] iv, input logic [31:0] fv,
                                    input int unsigned fc, input int unsigned len,
                                    input logic [15:0] row, input logic [15:0] col,
                                    input logic [2:0] err);
        t_exp_token t;
        t.kind   = kind;
        t.ival   = iv;
        t.fval   = fv;
        t.fcount = (fc > 255) ? 8'd255 : 8'(fc);
        t.len    = (len > 255) ? 8'd255 : 8'(len);
        t.row    = row;
        t.col    = col;
        t.err    = err;
        t.last   = 1'b0;
        toks.push_back(t);
    endfunction

    function automatic void raise_error(ref t_scan_state st, ref t_exp_token toks[$],
                                        input logic [2:0] err);
        put_tok(toks, K_ERROR, 0, 0, 0, 0, st.row, st.col, err);
        st.halted = 1'b1;
        st.mode   = SM_START;
    endfunction

    function automatic void grow_len(ref t_scan_state st);
        if (st.len < LEN_LIMIT) st.len++;
    endfunction

    function automatic void mark_start(ref t_scan_state st);
        st.trow = st.row;
        st.tcol = st.col;
        st.len  = 1;
    endfunction

    // close whatever token is open
    function automatic void flush_token(ref t_scan_state st, ref t_exp_token toks[$]);
        case (st.mode)
            SM_NUMBER:  put_tok(toks, K_INT, st.ival, 0, 0, st.len, st.trow, st.tcol, E_NONE);
            SM_DECIMAL: put_tok(toks, K_DEC, st.ival, st.fval, st.fdigits, st.len,
                                st.trow, st.tcol, E_NONE);
            SM_IDENT:   put_tok(toks, K_IDENT, 0, 0, 0, st.len, st.trow, st.tcol, E_NONE);
            SM_PLUS:    put_tok(toks, K_PLUS, 0, 0, 0, 1, st.trow, st.tcol, E_NONE);
            SM_MINUS:   put_tok(toks, K_MINUS, 0, 0, 0, 1, st.trow, st.tcol, E_NONE);
            default: ;
        endcase
        st.mode = SM_START;
    endfunction

    // byte seen from the start state
    function automatic void start_token(ref t_scan_state st, input logic [7:0] c,
                                        ref t_exp_token toks[$]);
        st.mode = SM_START;
        if (is_blank(c)) return;
        if (is_digit(c)) begin
            mark_start(st);
            st.ival    = 32'(c - CH_ZERO);
            st.fval    = '0;
            st.fdigits = '0;
            st.suffix  = 1'b0;
            st.mode    = SM_NUMBER;
        end else if (is_letter(c)) begin
            mark_start(st);
            st.mode = SM_IDENT;
        end else if (c == CH_PLUS) begin
            mark_start(st);
            st.mode = SM_PLUS;
        end else if (c == CH_MINUS) begin
            mark_start(st);
            st.mode = SM_MINUS;
        end else if (c == CH_STAR) begin
            put_tok(toks, K_MUL, 0, 0, 0, 1, st.row, st.col, E_NONE);
        end else if (c == CH_SLASH) begin
            put_tok(toks, K_DIV, 0, 0, 0, 1, st.row, st.col, E_NONE);
        end else if (c == CH_OPEN) begin
            put_tok(toks, K_OPEN, 0, 0, 0, 1, st.row, st.col, E_NONE);
        end else if (c == CH_CLOSE) begin
            put_tok(toks, K_CLOSE, 0, 0, 0, 1, st.row, st.col, E_NONE);
        end else if (c == CH_DOT) begin
            raise_error(st, toks, E_LONE_DOT);
        end else begin
            raise_error(st, toks, E_BAD_START);
        end
    endfunction

    // one input beat: update the scanner and append the tokens it yields
    function automatic void scan_step(ref t_scan_state st, input logic [7:0] c,
                                      input logic eoi, ref t_exp_token toks[$]);
        int base;
        base = toks.size();
        if (st.halted) return;
        if (eoi) begin
            flush_token(st, toks);
            put_tok(toks, K_END, 0, 0, 0, 0, st.row, st.col, E_NONE);
            st.row = 16'd1;
            st.col = '0;
        end else begin
            // position moves first
            if (c == CH_NL) begin
                if (st.row != 16'hFFFF) st.row++;
                st.col = '0;
            end else if (st.col != 16'hFFFF) begin
                st.col++;
            end
            case (st.mode)
                SM_NUMBER: begin
                    if (is_digit(c)) begin
                        st.ival = st.ival * 32'd10 + 32'(c - CH_ZERO);
                        grow_len(st);
                    end else if (is_letter(c)) begin
                        raise_error(st, toks, E_NUM_ALPHA);
                    end else if (c == CH_DOT) begin
                        grow_len(st);
                        st.fval    = '0;
                        st.fdigits = '0;
                        st.suffix  = 1'b0;
                        st.mode    = SM_DECIMAL;
                    end else begin
                        flush_token(st, toks);
                        start_token(st, c, toks);
                    end
                end
                SM_DECIMAL: begin
                    if (is_digit(c)) begin
                        st.fval = st.fval * 32'd10 + 32'(c - CH_ZERO);
                        if (st.fdigits != 8'd255) st.fdigits++;
                        grow_len(st);
                    end else if (is_letter(c)) begin
                        if (!st.suffix && (c == CH_LO_F || c == CH_UP_F)) st.suffix = 1'b1;
                        else raise_error(st, toks, E_DEC_ALPHA);
                    end else begin
                        flush_token(st, toks);
                        start_token(st, c, toks);
                    end
                end
                SM_IDENT: begin
                    if (is_digit(c) || is_letter(c)) begin
                        grow_len(st);
                    end else if (is_op_char(c)) begin
                        raise_error(st, toks, E_ID_SYMBOL);
                    end else begin
                        flush_token(st, toks);
                        start_token(st, c, toks);
                    end
                end
                SM_PLUS, SM_MINUS: begin
                    if ((st.mode == SM_PLUS && c == CH_PLUS) ||
                        (st.mode == SM_MINUS && c == CH_MINUS)) begin
                        put_tok(toks, (st.mode == SM_PLUS) ? K_INCR : K_DECR, 0, 0, 0, 2,
                                st.trow, st.tcol, E_NONE);
                        st.mode = SM_START;
                    end else begin
                        flush_token(st, toks);
                        start_token(st, c, toks);
                    end
                end
                default: start_token(st, c, toks);
            endcase
        end
        if (toks.size() > base) toks[toks.size() - 1].last = 1'b1;
    endfunction

    // random source text pieces
    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_letter();
        logic [7:0] off;
        off = 8'($urandom_range(0, 25));
        return $urandom_range(0, 1) ? CH_LO_A + off : CH_UP_A + off;
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 2))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            default: return CH_NL;
        endcase
    endfunction

    function automatic logic [7:0] rand_op(bit with_dot);
        case ($urandom_range(0, with_dot ? 6 : 5))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            3:       return CH_SLASH;
            4:       return CH_OPEN;
            5:       return CH_CLOSE;
            default: return CH_DOT;
        endcase
    endfunction

    function automatic int rand_len();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 4) : $urandom_range(9, 13);
    endfunction

    function automatic void add_byte(ref t_src_beat b[$], input logic [7:0] c);
        b.push_back(t_src_beat'{c, 1'b0});
    endfunction

    function automatic void make_number(ref t_src_beat b[$], input int n_int, input int n_frac,
                                        input bit with_dot, input bit sfx, input int n_tail);
        repeat (n_int) add_byte(b, rand_digit());
        if (with_dot) begin
            add_byte(b, CH_DOT);
            repeat (n_frac) add_byte(b, rand_digit());
            if (sfx) add_byte(b, $urandom_range(0, 1) ? CH_LO_F : CH_UP_F);
            repeat (n_tail) add_byte(b, rand_digit());
        end
    endfunction

    function automatic void make_ident(ref t_src_beat b[$], input int n);
        add_byte(b, rand_letter());
        repeat (n - 1) add_byte(b, $urandom_range(0, 2) ? rand_letter() : rand_digit());
    endfunction

    function automatic void make_random_piece(ref t_src_beat b[$]);
        int  pick;
        bit  dot;
        bit  sfx;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            dot = $urandom_range(0, 99) < 40;
            sfx = dot && $urandom_range(0, 2) == 0;
            make_number(b, rand_len(), ($urandom_range(0, 3) == 0) ? 0 : rand_len(), dot, sfx,
                        (sfx && $urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
        end else if (pick < 50) begin
            make_ident(b, rand_len());
        end else if (pick < 75) begin
            repeat ($urandom_range(1, 3)) add_byte(b, rand_op(1'b0));
        end else if (pick < 92) begin
            repeat ($urandom_range(1, 3)) add_byte(b, rand_blank());
        end else begin
            b.push_back(t_src_beat'{8'($urandom), 1'b1});
        end
    endfunction

    // would this text, from the given state, raise an error
    function automatic bit text_is_clean(input t_scan_state st, input t_src_beat b[$]);
        t_exp_token toks[$];
        foreach (b[i]) scan_step(st, b[i].ch, b[i].eoi, toks);
        foreach (toks[i]) if (toks[i].kind == K_ERROR) return 1'b0;
        return 1'b1;
    endfunction

    // hand beats to the driver, tracking the scanner state they lead to
    function automatic void queue_beats(input t_src_beat b[$]);
        t_exp_token scratch[$];
        foreach (b[i]) begin
            scan_step(gen_model, b[i].ch, b[i].eoi, scratch);
            source_beats.push_back(b[i]);
            beats_queued++;
        end
    endfunction

    // separate from the open token when needed so no error is raised
    function automatic void queue_clean(input t_src_beat b[$]);
        if (!text_is_clean(gen_model, b)) b.push_front(t_src_beat'{rand_blank(), 1'b0});
        queue_beats(b);
    endfunction

    function automatic void queue_random(input int n);
        t_src_beat b[$];
        int        goal;
        goal = beats_queued + n;
        while (beats_queued < goal) begin
            b.delete();
            make_random_piece(b);
            queue_clean(b);
        end
    endfunction

    // every operator, boundaries, suffix with trailing digits, end marks
    function automatic void queue_directed();
        string     txt;
        t_src_beat b[$];
        txt = "9+0++x1 --7-(*/)\t\n4.05f2 12";
        for (int i = 0; i < txt.len(); i++) add_byte(b, txt[i]);
        b.push_back(t_src_beat'{8'hFF, 1'b1});
        b.push_back(t_src_beat'{8'h00, 1'b1});
        queue_beats(b);
    endfunction

    // long lexemes: length and fraction digit count saturate
    function automatic void queue_saturation();
        t_src_beat b[$];
        add_byte(b, CH_SPACE);
        make_ident(b, 258);
        queue_clean(b);
        b.delete();
        add_byte(b, CH_SPACE);
        make_number(b, 3, 257, 1'b1, 1'b1, 2);
        queue_clean(b);
        b.delete();
        b.push_back(t_src_beat'{8'h80, 1'b1});
        queue_beats(b);
    endfunction

    // an error halts the block for good, so one kind closes the run
    function automatic void queue_error_tail();
        t_src_beat  b[$];
        logic [7:0] c;
        logic [2:0] pick;
        pick = 3'($urandom_range(E_BAD_START, E_LONE_DOT));
        add_byte(b, CH_SPACE);
        case (pick)
            E_BAD_START: begin
                if ($urandom_range(0, 1)) make_number(b, rand_len(), 0, 1'b0, 1'b0, 0);
                do c = 8'($urandom_range(0, 255));
                while (is_digit(c) || is_letter(c) || is_op_char(c) || is_blank(c));
                add_byte(b, c);
            end
            E_NUM_ALPHA: begin
                make_number(b, rand_len(), 0, 1'b0, 1'b0, 0);
                add_byte(b, rand_letter());
            end
            E_DEC_ALPHA: begin
                if ($urandom_range(0, 1)) begin
                    make_number(b, rand_len(), rand_len(), 1'b1, 1'b1, 0);
                    add_byte(b, rand_letter());
                end else begin
                    make_number(b, rand_len(), rand_len(), 1'b1, 1'b0, 0);
                    do c = rand_letter(); while (c == CH_LO_F || c == CH_UP_F);
                    add_byte(b, c);
                end
            end
            E_ID_SYMBOL: begin
                make_ident(b, rand_len());
                add_byte(b, rand_op(1'b1));
            end
            default: begin
                if ($urandom_range(0, 1)) make_number(b, rand_len(), rand_len(), 1'b1, 1'b0, 0);
                add_byte(b, CH_DOT);
            end
        endcase
        // halted: these must all vanish
        repeat (20) b.push_back(t_src_beat'{8'($urandom), 1'($urandom)});
        queue_beats(b);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic wait_drained();
        while (beats_taken != beats_queued || tokens_due.size() != 0) @(posedge clk);
    endtask

    // clock
    initial clk = 1'b0;
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // cycle limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // driver: next beat once the current one is taken, random gaps and stalls
    always @(negedge clk) begin
        t_src_beat nb;
        if (!rst_n) begin
            in_if.valid  <= 1'b0;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
            if (beats_taken == beats_sent) begin
                if (source_beats.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    nb = source_beats.pop_front();
                    in_if.valid        <= 1'b1;
                    in_if.char_code    <= nb.ch;
                    in_if.end_of_input <= nb.eoi;
                    beats_sent++;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: predict on each input beat, check each output beat
    always @(posedge clk) begin
        t_exp_token want;
        if (rst_n) begin
            if (in_if.valid && in_if.ready) begin
                scan_step(scanner_model, in_if.char_code, in_if.end_of_input, tokens_due);
                beats_taken++;
            end
            if (out_if.valid && out_if.ready) begin
                if (tokens_due.size() == 0) begin
                    $error("token kind %0d at %0d:%0d with none expected",
                           out_if.token_kind, out_if.start_row, out_if.start_col);
                    fail_count++;
                end else begin
                    want = tokens_due.pop_front();
                    check_field("token_kind", want.kind, out_if.token_kind);
                    check_field("int_value", want.ival, out_if.int_value);
                    check_field("frac_value", want.fval, out_if.frac_value);
                    check_field("frac_count", want.fcount, out_if.frac_count);
                    check_field("lexeme_length", want.len, out_if.lexeme_length);
                    check_field("start_row", want.row, out_if.start_row);
                    check_field("start_col", want.col, out_if.start_col);
                    check_field("error_kind", want.err, out_if.error_kind);
                    check_field("last", want.last, out_if.last);
                end
            end
        end
    end

    // stimulus phases
    initial begin
        rst_n              = 1'b0;
        in_if.valid        = 1'b0;
        in_if.char_code    = '0;
        in_if.end_of_input = 1'b0;
        out_if.ready       = 1'b0;
        beats_queued       = 0;
        beats_sent         = 0;
        beats_taken        = 0;
        fail_count         = 0;
        cycle_count        = 0;
        sender_idle_pct    = 31;
        receiver_idle_pct  = 82;
        scanner_model      = scan_reset();
        gen_model          = scan_reset();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // slow receiver
        queue_directed();
        queue_random(100);
        wait_drained();

        // slow sender, after a full drain
        sender_idle_pct   = 82;
        receiver_idle_pct = 31;
        queue_random(100);
        wait_drained();

        // full rate, then the error that ends scanning
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        queue_saturation();
        queue_random(50);
        queue_error_tail();
        wait_drained();
        repeat (20) @(posedge clk);

        if (fail_count == 0 && tokens_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
